// ----- hw/rtl/trial_division_factorizer_assert.svh -----
`ifndef TRIAL_DIVISION_FACTORIZER_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_ASSERT_SVH

// Both macros expect clk and arst_n in the scope where they are used.

// The consequent must hold in the same cycle as the antecedent.
`define TDF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdf assertion failed");

`endif

// ----- hw/rtl/tdf_pkg.sv -----
package tdf_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int FIRST_DIVISOR = 3;
	localparam int DIVISOR_STEP = 2;
	localparam int EVEN_FACTOR = 2;

	typedef enum logic [2:0] {
		SRC_RAW,
		SRC_NEG1,
		SRC_TWO,
		SRC_DIV,
		SRC_REM
	} src_t;

	typedef struct packed {
		logic load;
		logic emit;
		src_t src;
		logic last;
		logic shift2;
		logic div_start;
		logic take_quo;
		logic next_div;
	} cmd_t;

	typedef struct packed {
		logic is_trivial;
		logic is_neg;
		logic mag_one;
		logic rem_even;
		logic rem_two;
		logic div_busy;
		logic d_gt_q;
		logic rmd_zero;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/tdf_div.sv -----
module tdf_div #(
	parameter int W = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quo,
	output logic [W-1:0] rmd
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  acc_q;
	logic [W:0]    sh;
	logic [W:0]    diff;
	logic          ge;

	// One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
	assign sh   = {acc_q, quo_q[W-1]};
	assign diff = sh - {1'b0, divisor};
	assign ge   = sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[W-2:0], ge};
			acc_q <= ge ? diff[W-1:0] : sh[W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;
	assign rmd  = acc_q;

endmodule

// ----- hw/rtl/tdf_dp.sv -----
module tdf_dp #(
	parameter int W = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [W-1:0] number,
	input  tdf_pkg::cmd_t       cmd,
	output tdf_pkg::sts_t       sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [W-1:0] factor_value,
	output logic                last_factor
);

	localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] raw_q;
	logic         neg_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] d_q;
	logic         out_valid_q;
	logic [W-1:0] val_q;
	logic         last_q;
	logic [W-1:0] mag;
	logic [W-1:0] mag_sat;
	logic [W-1:0] emit_val;
	logic         div_busy;
	logic [W-1:0] quo;
	logic [W-1:0] rmd;

	// The most negative value has no positive counterpart and saturates to the largest one.
	assign mag     = ~number + W'(1);
	assign mag_sat = (mag == SIGN_BIT) ? (SIGN_BIT - W'(1)) : mag;

	tdf_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rem_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.quo      (quo),
		.rmd      (rmd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= number;
			neg_q <= number[W-1];
			rem_q <= number[W-1] ? mag_sat : number;
			d_q   <= W'(tdf_pkg::FIRST_DIVISOR);
		end else begin
			if (cmd.shift2) begin
				rem_q <= rem_q >> 1;
			end else if (cmd.take_quo) begin
				rem_q <= quo;
			end
			if (cmd.next_div) begin
				d_q <= d_q + W'(tdf_pkg::DIVISOR_STEP);
			end
		end
	end

	always_comb begin
		unique case (cmd.src)
			tdf_pkg::SRC_RAW:  emit_val = raw_q;
			tdf_pkg::SRC_NEG1: emit_val = '1;
			tdf_pkg::SRC_TWO:  emit_val = W'(tdf_pkg::EVEN_FACTOR);
			tdf_pkg::SRC_DIV:  emit_val = d_q;
			tdf_pkg::SRC_REM:  emit_val = rem_q;
			default:           emit_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			val_q  <= emit_val;
			last_q <= cmd.last;
		end
	end

	assign sts.is_trivial = (raw_q == '0) || (raw_q == W'(1));
	assign sts.is_neg     = neg_q;
	assign sts.mag_one    = rem_q == W'(1);
	assign sts.rem_even   = !rem_q[0];
	assign sts.rem_two    = rem_q == W'(tdf_pkg::EVEN_FACTOR);
	assign sts.div_busy   = div_busy;
	assign sts.d_gt_q     = d_q > quo;
	assign sts.rmd_zero   = rmd == '0;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign factor_value = val_q;
	assign last_factor  = last_q;

endmodule

// ----- hw/rtl/tdf_ctrl.sv -----
`include "trial_division_factorizer_assert.svh"

module tdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tdf_pkg::sts_t sts,
	output tdf_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_TWOS  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		cmd.src  = tdf_pkg::SRC_RAW;
		state_d  = state_q;
		in_ready = state_q == ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.is_trivial) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.src  = tdf_pkg::SRC_RAW;
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (sts.is_neg) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.src  = tdf_pkg::SRC_NEG1;
						cmd.last = sts.mag_one;
						state_d  = sts.mag_one ? ST_IDLE : ST_TWOS;
					end
				end else begin
					state_d = ST_TWOS;
				end
			end
			ST_TWOS: begin
				if (sts.rem_even) begin
					if (sts.out_free) begin
						cmd.emit   = 1'b1;
						cmd.src    = tdf_pkg::SRC_TWO;
						cmd.last   = sts.rem_two;
						cmd.shift2 = 1'b1;
						if (sts.rem_two) begin
							state_d = ST_IDLE;
						end
					end
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (!sts.div_busy) begin
					if (sts.d_gt_q) begin
						// The divisor squared exceeds the remainder, so the remainder is prime.
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.src  = tdf_pkg::SRC_REM;
							cmd.last = 1'b1;
							state_d  = ST_IDLE;
						end
					end else if (sts.rmd_zero) begin
						if (sts.out_free) begin
							cmd.emit     = 1'b1;
							cmd.src      = tdf_pkg::SRC_DIV;
							cmd.take_quo = 1'b1;
							state_d      = ST_DIV;
						end
					end else begin
						cmd.next_div = 1'b1;
						state_d      = ST_DIV;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TDF_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free)
	`TDF_ASSERT_NOW(a_start_idle, cmd.div_start, !sts.div_busy)
	`TDF_ASSERT_NEXT(a_div_busy, cmd.div_start, sts.div_busy)
	`TDF_ASSERT_NEXT(a_accept_start, in_valid && in_ready, state_q == ST_START)

endmodule

// ----- hw/rtl/trial_division_factorizer.sv -----
// Trial-division factorizer. The input channel (in_valid, in_ready, number) takes one
// signed value per transaction. The output channel (out_valid, out_ready, factor_value,
// last_factor) gives its prime factors in ascending order, one transaction per factor,
// with last_factor high on the final one. Zero and one are echoed; a negative value first
// gives -1 and is then factored by its magnitude.
// One value is handled at a time: in_ready is high only while the block is idle.
// The first result for zero, one or a negative value is emitted from the start state,
// for a positive even value from the factor-of-two state, and for a positive odd value
// only after its first trial division. Factors of two are removed by shifting. Each odd
// trial divisor is tested in the serial restoring divider, which yields quotient and
// remainder together; the divisor runs from 3 up to about the square root of the
// remainder, so a 31-bit prime needs about 23,000 trials, while values with small
// factors finish far sooner.
// A held result in the output register stalls the sequencer at its next factor until
// out_ready takes it, so a stalled receiver simply pauses the computation; nothing is lost.
// Reset clears the sequencer, the divider count and the output valid flag.
module trial_division_factorizer #(
	parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] factor_value,
	output logic                         last_factor
);

	tdf_pkg::cmd_t cmd;
	tdf_pkg::sts_t sts;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdf_dp #(.W(VALUE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.number       (number),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.factor_value (factor_value),
		.last_factor  (last_factor)
	);

endmodule

// ----- sim/factor_checker.sv -----
module factor_checker #(
	parameter int VB = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [VB-1:0] number,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [VB-1:0] factor_value,
	input  logic                 last_factor,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [VB-1:0] SIGN_BIT = {1'b1, {(VB-1){1'b0}}};

	typedef struct packed {
		logic [VB-1:0] value;
		logic          last;
	} factor_t;

	factor_t expected_factors [$];

	function automatic void push_factor(input logic [VB-1:0] value);
		factor_t f;
		f.value = value;
		f.last = 1'b0;
		expected_factors.push_back(f);
	endfunction

	// Negative values give -1 first and are then factored by magnitude.
	function automatic void predict_factors(input logic [VB-1:0] raw);
		logic [VB-1:0] rem;
		logic [VB-1:0] d;
		if (raw == 0 || raw == 1) begin
			push_factor(raw);
		end else begin
			if (raw[VB-1]) begin
				push_factor('1);
				rem = -raw;
				if (rem == SIGN_BIT) begin
					rem = SIGN_BIT - 1;
				end
			end else begin
				rem = raw;
			end
			while (rem != 0 && !rem[0]) begin
				push_factor(tdf_pkg::EVEN_FACTOR);
				rem = rem >> 1;
			end
			for (d = tdf_pkg::FIRST_DIVISOR; d <= rem / d; d += tdf_pkg::DIVISOR_STEP) begin
				while (rem % d == 0) begin
					push_factor(d);
					rem = rem / d;
				end
			end
			if (rem > tdf_pkg::EVEN_FACTOR) begin
				push_factor(rem);
			end
		end
		expected_factors[expected_factors.size()-1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		factor_t head;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_factors(number);
			end
			if (out_valid && out_ready) begin
				if (expected_factors.size() == 0) begin
					$display("%0t: unexpected factor transaction, expected none, got %0d last %0b",
						$time, factor_value, last_factor);
					fail_count++;
				end else begin
					head = expected_factors.pop_front();
					if (factor_value !== head.value) begin
						$display("%0t: factor_value mismatch, expected %0d, got %0d",
							$time, $signed(head.value), factor_value);
						fail_count++;
					end
					if (last_factor !== head.last) begin
						$display("%0t: last_factor mismatch, expected %0b, got %0b",
							$time, head.last, last_factor);
						fail_count++;
					end
				end
			end
			pending = expected_factors.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VB = tdf_pkg::VALUE_BITS_DEF;
	localparam longint MAX_MAG = (longint'(1) << (VB-1)) - 1;
	localparam int WATCHDOG_LIMIT = 4_000_000;
	localparam int PHASE_ITEMS = 25;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [VB-1:0] number;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [VB-1:0] factor_value;
	logic                 last_factor;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	int small_primes [15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

	// Zero, one and minus one, squares of primes, the longest result list, and the
	// largest magnitude, whose factor is a 31-bit prime.
	int directed_numbers [20] = '{
		0, 1, -1, 2, -2, 3, 4, 9, 15, 121,
		65521, 16752649, 223092870, 1162261467, 1431655765,
		1073741824, -1073741824, 2147483646, -2147483646, -2147483647
	};

	trial_division_factorizer #(
		.VALUE_BITS(VB)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.number      (number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.factor_value(factor_value),
		.last_factor (last_factor)
	);

	factor_checker #(
		.VB(VB)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.number      (number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.factor_value(factor_value),
		.last_factor (last_factor),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Products of small primes keep the trial loop short while reaching the top bits.
	function automatic logic signed [VB-1:0] random_number();
		longint product;
		int picks;
		int p;
		int r;
		if ($urandom_range(99) < 15) begin
			return $urandom_range(2000) - 1000;
		end
		product = 1;
		picks = $urandom_range(40, 1);
		repeat (picks) begin
			p = small_primes[$urandom_range(14)];
			if (product * p > MAX_MAG) begin
				break;
			end
			product = product * p;
		end
		if ($urandom_range(1)) begin
			r = 2 * $urandom_range(2047, 1) + 1;
			if (product * r <= MAX_MAG) begin
				product = product * r;
			end
		end
		if ($urandom_range(1)) begin
			product = -product;
		end
		return product[VB-1:0];
	endfunction

	task automatic send_number(input logic signed [VB-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			number = $urandom;
			@(negedge clk);
		end
		in_valid = 1'b1;
		number = value;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		number = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_numbers[i]) begin
			send_number(directed_numbers[i]);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 46;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			repeat (PHASE_ITEMS) send_number(random_number());
		end

		in_valid = 1'b0;
		recv_stall_pct = 0;
		do begin
			@(negedge clk);
		end while (pending != 0);
		repeat (40) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
